// ===== sv/convex_cell_point_test_defines.svh =====
// Assertion helpers used by the block's controller.
`ifndef CONVEX_CELL_POINT_TEST_DEFINES_SVH
`define CONVEX_CELL_POINT_TEST_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define CCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define CCP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/ccpt_pkg.sv =====
// ---------------------------------------------------------------------------
// ccpt_pkg
// Types, codes and sizes shared by the convex cell point test block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ccpt_pkg;

    localparam int COORD_BITS   = 16;
    localparam int MAX_EDGES_DF = 64;
    localparam int HELD_W       = 7;
    localparam int CFG_IDX_W    = 1;

    // operation codes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_TEST  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FOCUS_X = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOCUS_Y = 1'd1;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic [1:0] opcode;
        coord_t     start_x;
        coord_t     start_y;
        coord_t     end_x;
        coord_t     end_y;
        logic       start_present;
        logic       end_present;
        coord_t     query_x;
        coord_t     query_y;
    } item_t;

    typedef struct packed {
        logic              inside_res;
        logic              complete;
        logic              status;
        logic [HELD_W-1:0] edges_held;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic load_item;
        logic clear_cell;
        logic drop;
        logic load_orient;
        logic mul;
        logic store_edge;
        logic scan_step;
        logic append;
        logic rm_read;
        logic rm_write;
        logic sel_b;
        logic test_init;
        logic edge_read;
        logic load_test;
        logic test_fail;
        logic test_next;
        logic respond;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] opcode;
        logic       both;
        logic       full;
        logic       complete;
        logic       neg;
        logic       found;
        logic       scan_done;
        logic       pt_is_b;
        logic       edges_done;
    } dp_stat_t;

endpackage

// ===== sv/ccpt_ram.sv =====
// ---------------------------------------------------------------------------
// ccpt_ram
// Generic one-write, one-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/ccpt_datapath.sv =====
// ---------------------------------------------------------------------------
// ccpt_datapath
// Edge and open-point stores, counters, cross-product unit and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccpt_datapath #(
    parameter int MAX_EDGES = ccpt_pkg::MAX_EDGES_DF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ccpt_pkg::item_t                  item,
    input  logic                             cfg_we,
    input  logic [ccpt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ccpt_pkg::COORD_BITS-1:0]  cfg_data,
    input  ccpt_pkg::dp_cmd_t                cmd,
    output ccpt_pkg::dp_stat_t               stat,
    output ccpt_pkg::result_t                result,
    output logic                             result_valid
);

    localparam int CB   = ccpt_pkg::COORD_BITS;
    localparam int DW   = CB + 1;
    localparam int PW   = 2 * DW;
    localparam int OCAP = 2 * MAX_EDGES;
    localparam int EA   = $clog2(MAX_EDGES);
    localparam int ECW  = $clog2(MAX_EDGES + 1);
    localparam int OA   = $clog2(OCAP);
    localparam int OCW  = $clog2(OCAP + 1);

    // configuration
    logic signed [CB-1:0] fx_reg, fy_reg;

    // current item
    logic [1:0]           op_reg;
    logic                 both_reg;
    logic signed [CB-1:0] ax_reg, ay_reg, bx_reg, by_reg, qx_reg, qy_reg;

    // counters and flags
    logic [ECW-1:0] edge_cnt_reg, tidx_reg;
    logic [OCW-1:0] open_cnt_reg, scan_idx_reg;
    logic [OA-1:0]  pend_idx_reg;
    logic           pend_vld_reg, pt_sel_reg, broken_reg;
    logic           inside_reg, drop_reg;

    // cross-product unit
    logic signed [DW-1:0] ux_reg, uy_reg, vx_reg, vy_reg;
    logic signed [PW-1:0] p_reg, q_reg;

    // result
    ccpt_pkg::result_t res_reg;
    logic              res_vld_reg;

    // RAM ports
    logic              e_we, e_re, o_we, o_re;
    logic [4*CB-1:0]   e_wdata, e_rdata;
    logic [2*CB-1:0]   o_wdata, o_rdata, pt;
    logic [OA-1:0]     o_waddr, o_raddr;
    logic [OCW-1:0]    last_idx;
    logic              swap, complete;
    logic signed [CB-1:0] rax, ray, rbx, rby;

    ccpt_ram #(.WIDTH(4 * CB), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (edge_cnt_reg[EA-1:0]),
        .wdata (e_wdata),
        .re    (e_re),
        .raddr (tidx_reg[EA-1:0]),
        .rdata (e_rdata)
    );

    ccpt_ram #(.WIDTH(2 * CB), .DEPTH(OCAP)) u_open_ram (
        .clk   (clk),
        .we    (o_we),
        .waddr (o_waddr),
        .wdata (o_wdata),
        .re    (o_re),
        .raddr (o_raddr),
        .rdata (o_rdata)
    );

    // store access and status
    always_comb
    begin
        swap     = both_reg && (p_reg < q_reg);
        pt       = pt_sel_reg ? {bx_reg, by_reg} : {ax_reg, ay_reg};
        last_idx = open_cnt_reg - OCW'(1);
        complete = (open_cnt_reg == '0) && !broken_reg;
        e_we     = cmd.store_edge;
        e_re     = cmd.edge_read;
        e_wdata  = swap ? {bx_reg, by_reg, ax_reg, ay_reg} : {ax_reg, ay_reg, bx_reg, by_reg};
        {rax, ray, rbx, rby} = e_rdata;
        o_we     = (cmd.append && (open_cnt_reg < OCW'(OCAP))) || cmd.rm_write;
        o_waddr  = cmd.rm_write ? pend_idx_reg : open_cnt_reg[OA-1:0];
        o_wdata  = cmd.rm_write ? o_rdata : pt;
        o_re     = cmd.scan_step || cmd.rm_read;
        o_raddr  = cmd.rm_read ? last_idx[OA-1:0] : scan_idx_reg[OA-1:0];

        stat.opcode     = op_reg;
        stat.both       = both_reg;
        stat.full       = (edge_cnt_reg >= ECW'(MAX_EDGES));
        stat.complete   = complete;
        stat.neg        = (p_reg < q_reg);
        stat.found      = pend_vld_reg && (o_rdata == pt);
        stat.scan_done  = (scan_idx_reg >= open_cnt_reg);
        stat.pt_is_b    = pt_sel_reg;
        stat.edges_done = (tidx_reg == edge_cnt_reg);
    end

    // focus registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fx_reg <= '0;
            fy_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == ccpt_pkg::REG_FOCUS_X)
            begin
                fx_reg <= cfg_data;
            end
            if (cfg_index == ccpt_pkg::REG_FOCUS_Y)
            begin
                fy_reg <= cfg_data;
            end
        end
    end

    // item payload, operands, products
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg   <= item.opcode;
            both_reg <= item.start_present && item.end_present;
            ax_reg   <= item.start_x;
            ay_reg   <= item.start_y;
            bx_reg   <= item.end_x;
            by_reg   <= item.end_y;
            qx_reg   <= item.query_x;
            qy_reg   <= item.query_y;
        end
        else if (cmd.store_edge && swap)
        begin
            ax_reg <= bx_reg;
            ay_reg <= by_reg;
            bx_reg <= ax_reg;
            by_reg <= ay_reg;
        end
        if (cmd.load_orient)
        begin
            ux_reg <= DW'(ax_reg) - DW'(fx_reg);
            uy_reg <= DW'(ay_reg) - DW'(fy_reg);
            vx_reg <= DW'(bx_reg) - DW'(fx_reg);
            vy_reg <= DW'(by_reg) - DW'(fy_reg);
        end
        else if (cmd.load_test)
        begin
            ux_reg <= DW'(rbx) - DW'(rax);
            uy_reg <= DW'(rby) - DW'(ray);
            vx_reg <= DW'(qx_reg) - DW'(rax);
            vy_reg <= DW'(qy_reg) - DW'(ray);
        end
        if (cmd.mul)
        begin
            p_reg <= PW'(ux_reg) * PW'(vy_reg);
            q_reg <= PW'(uy_reg) * PW'(vx_reg);
        end
    end

    // counters, scan state, flags, result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_cnt_reg <= '0;
            open_cnt_reg <= '0;
            broken_reg   <= 1'b0;
            tidx_reg     <= '0;
            scan_idx_reg <= '0;
            pend_idx_reg <= '0;
            pend_vld_reg <= 1'b0;
            pt_sel_reg   <= 1'b0;
            inside_reg   <= 1'b0;
            drop_reg     <= 1'b0;
            res_reg      <= '0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            res_vld_reg <= cmd.respond;
            if (cmd.load_item)
            begin
                inside_reg <= 1'b0;
                drop_reg   <= 1'b0;
            end
            if (cmd.clear_cell)
            begin
                edge_cnt_reg <= '0;
                open_cnt_reg <= '0;
                broken_reg   <= 1'b0;
            end
            if (cmd.drop)
            begin
                drop_reg <= 1'b1;
            end
            if (cmd.store_edge)
            begin
                edge_cnt_reg <= edge_cnt_reg + ECW'(1);
                broken_reg   <= broken_reg || !both_reg;
            end
            // a new point scan starts for each endpoint
            if (cmd.store_edge || cmd.sel_b)
            begin
                pt_sel_reg   <= cmd.sel_b;
                scan_idx_reg <= '0;
                pend_vld_reg <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                pend_idx_reg <= scan_idx_reg[OA-1:0];
                pend_vld_reg <= 1'b1;
                scan_idx_reg <= scan_idx_reg + OCW'(1);
            end
            if (cmd.append && (open_cnt_reg < OCW'(OCAP)))
            begin
                open_cnt_reg <= open_cnt_reg + OCW'(1);
            end
            if (cmd.rm_write)
            begin
                open_cnt_reg <= last_idx;
            end
            if (cmd.test_init)
            begin
                inside_reg <= 1'b1;
                tidx_reg   <= '0;
            end
            if (cmd.test_fail)
            begin
                inside_reg <= 1'b0;
            end
            if (cmd.test_next)
            begin
                tidx_reg <= tidx_reg + ECW'(1);
            end
            if (cmd.respond)
            begin
                res_reg.inside_res <= inside_reg;
                res_reg.complete   <= complete;
                res_reg.status     <= drop_reg;
                res_reg.edges_held <= ccpt_pkg::HELD_W'(edge_cnt_reg);
            end
        end
    end

    assign result       = res_reg;
    assign result_valid = res_vld_reg;

endmodule

// ===== sv/ccpt_ctrl.sv =====
// ---------------------------------------------------------------------------
// ccpt_ctrl
// Sequencer for clear, add-edge and test-point operations.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "convex_cell_point_test_defines.svh"

module ccpt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ccpt_pkg::dp_stat_t stat,
    output ccpt_pkg::dp_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_OMUL  = 4'd2;
    localparam logic [3:0] S_OCMP  = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_RMRD  = 4'd5;
    localparam logic [3:0] S_RMWR  = 4'd6;
    localparam logic [3:0] S_NEXT  = 4'd7;
    localparam logic [3:0] S_TRD   = 4'd8;
    localparam logic [3:0] S_TDIF  = 4'd9;
    localparam logic [3:0] S_TMUL  = 4'd10;
    localparam logic [3:0] S_TCMP  = 4'd11;
    localparam logic [3:0] S_RESP  = 4'd12;

    logic [3:0] state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DISP;
                end
            end
            S_DISP:
            begin
                case (stat.opcode)
                    ccpt_pkg::OP_CLEAR:
                    begin
                        cmd.clear_cell = 1'b1;
                        state_next     = S_RESP;
                    end
                    ccpt_pkg::OP_ADD:
                    begin
                        if (stat.full)
                        begin
                            cmd.drop   = 1'b1;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            cmd.load_orient = 1'b1;
                            state_next      = S_OMUL;
                        end
                    end
                    ccpt_pkg::OP_TEST:
                    begin
                        if (stat.complete)
                        begin
                            cmd.test_init = 1'b1;
                            state_next    = S_TRD;
                        end
                        else
                        begin
                            state_next = S_RESP;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_OMUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_OCMP;
            end
            S_OCMP:
            begin
                cmd.store_edge = 1'b1;
                state_next     = stat.both ? S_SCAN : S_RESP;
            end
            // look for the endpoint among the open points
            S_SCAN:
            begin
                if (stat.found)
                begin
                    cmd.rm_read = 1'b1;
                    state_next  = S_RMRD;
                end
                else if (stat.scan_done)
                begin
                    cmd.append = 1'b1;
                    state_next = S_NEXT;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_RMRD:
            begin
                state_next = S_RMWR;
            end
            S_RMWR:
            begin
                cmd.rm_write = 1'b1;
                state_next   = S_NEXT;
            end
            S_NEXT:
            begin
                if (stat.pt_is_b)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.sel_b  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            // walk the edges, one cross product each
            S_TRD:
            begin
                if (stat.edges_done)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.edge_read = 1'b1;
                    state_next    = S_TDIF;
                end
            end
            S_TDIF:
            begin
                cmd.load_test = 1'b1;
                state_next    = S_TMUL;
            end
            S_TMUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_TCMP;
            end
            S_TCMP:
            begin
                if (stat.neg)
                begin
                    cmd.test_fail = 1'b1;
                    state_next    = S_RESP;
                end
                else
                begin
                    cmd.test_next = 1'b1;
                    state_next    = S_TRD;
                end
            end
            S_RESP:
            begin
                cmd.respond = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    `CCP_ASSERT_NEXT(a_resp_once, state_reg == S_RESP, state_reg == S_IDLE, "respond not single")
    `CCP_ASSERT_NEXT(a_accept, start && !busy, state_reg == S_DISP, "accepted item not dispatched")
    `CCP_ASSERT_NEXT(a_full_drop, state_reg == S_DISP && stat.opcode == ccpt_pkg::OP_ADD && stat.full, state_reg == S_RESP, "full store add not dropped")
    `CCP_ASSERT_NOW(a_one_ram_op, state_reg == S_SCAN, !(cmd.append && cmd.rm_read), "scan issued two ops")

endmodule

// ===== sv/convex_cell_point_test.sv =====
// ---------------------------------------------------------------------------
// convex_cell_point_test
// Convex cell store with point containment test by integer cross products.
// ---------------------------------------------------------------------------
// An add of an edge with both endpoints scans the open points for each endpoint, removing a
// match or appending the point; a test of a complete cell walks the edges until one fails.
// One item at a time; the open-point scan and the per-edge multiply loop set the rate.
// Result is strobed one cycle, and busy drops in that same cycle.
// Reset is asynchronous active low: cell empty, focus at 0; no clearing pass.
`timescale 1ns / 1ps

module convex_cell_point_test #(
    parameter int MAX_EDGES = ccpt_pkg::MAX_EDGES_DF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  ccpt_pkg::item_t                 item,
    output ccpt_pkg::result_t               result,
    output logic                            result_valid,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ccpt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ccpt_pkg::COORD_BITS-1:0] cfg_data
);

    ccpt_pkg::dp_cmd_t  cmd;
    ccpt_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    ccpt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    ccpt_datapath #(.MAX_EDGES(MAX_EDGES)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

// ===== tb/convex_cell_point_test_test.sv =====
// ---------------------------------------------------------------------------
// convex_cell_point_test_test
// Self-checking bench for the convex cell point test block. A directed table
// covers reset state, the unused opcode, broken edges and coordinate extremes.
// It is followed by random convex cells built around the focus, with broken
// cells, store overflow and noise mixed in. Every result is compared against
// an expected value from the table or an in-bench model of the cell.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module convex_cell_point_test_test;
    import ccpt_pkg::*;

    localparam int N_EDGES  = 64;
    localparam int N_OPEN   = 2 * N_EDGES;
    localparam int N_ITEMS  = 1350;
    localparam logic [1:0] OP_NOP = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    item_t                 item;
    result_t               result;
    logic                  result_valid;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [COORD_BITS-1:0] cfg_data;

    convex_cell_point_test #(.MAX_EDGES(N_EDGES)) DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .result(result), .result_valid(result_valid), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // cell model state
    longint  focus_x, focus_y;
    longint  edge_ax [N_EDGES];
    longint  edge_ay [N_EDGES];
    longint  edge_bx [N_EDGES];
    longint  edge_by [N_EDGES];
    int      edge_cnt;
    longint  open_x [N_OPEN];
    longint  open_y [N_OPEN];
    int      open_cnt;
    bit      broken;

    result_t expected_results[$];
    int      n_errors;
    int      n_results;
    int      n_inside;
    int      n_dropped;
    int      n_tests;
    int      n_sent;
    int      idle_pct;

    typedef struct {
        item_t   it;
        bit      typed;
        result_t r;
    } row_t;

    row_t table_rows[$];

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int cross_sign(longint ux, longint uy, longint vx, longint vy);
        longint p;
        longint q;
        p = ux * vy;
        q = uy * vx;
        return (p > q) ? 1 : ((p < q) ? -1 : 0);
    endfunction

    function automatic void toggle_open(longint x, longint y);
        for (int i = 0; i < open_cnt; i++)
        begin
            if (open_x[i] == x && open_y[i] == y)
            begin
                open_cnt--;
                open_x[i] = open_x[open_cnt];
                open_y[i] = open_y[open_cnt];
                return;
            end
        end
        if (open_cnt < N_OPEN)
        begin
            open_x[open_cnt] = x;
            open_y[open_cnt] = y;
            open_cnt++;
        end
    endfunction

    // advance the cell model by one item and return its result
    function automatic result_t cell_step(item_t it);
        result_t r;
        longint  ax, ay, bx, by, t, px, py;
        bit      both;
        bit      done;
        r = '0;
        if (it.opcode == OP_CLEAR)
        begin
            edge_cnt = 0;
            open_cnt = 0;
            broken   = 1'b0;
        end
        else if (it.opcode == OP_ADD)
        begin
            if (edge_cnt >= N_EDGES)
                r.status = 1'b1;
            else
            begin
                ax = it.start_x; ay = it.start_y;
                bx = it.end_x;   by = it.end_y;
                both = it.start_present && it.end_present;
                if (both && cross_sign(ax - focus_x, ay - focus_y,
                                       bx - focus_x, by - focus_y) < 0)
                begin
                    t = ax; ax = bx; bx = t;
                    t = ay; ay = by; by = t;
                end
                edge_ax[edge_cnt] = ax; edge_ay[edge_cnt] = ay;
                edge_bx[edge_cnt] = bx; edge_by[edge_cnt] = by;
                edge_cnt++;
                if (both)
                begin
                    toggle_open(ax, ay);
                    toggle_open(bx, by);
                end
                else
                    broken = 1'b1;
            end
        end
        r.complete = (open_cnt == 0) && !broken;
        if (it.opcode == OP_TEST && r.complete)
        begin
            px = it.query_x;
            py = it.query_y;
            r.inside_res = 1'b1;
            done = 1'b0;
            for (int i = 0; i < edge_cnt && !done; i++)
            begin
                if (cross_sign(edge_bx[i] - edge_ax[i], edge_by[i] - edge_ay[i],
                               px - edge_ax[i], py - edge_ay[i]) < 0)
                begin
                    r.inside_res = 1'b0;
                    done = 1'b1;
                end
            end
        end
        r.edges_held = edge_cnt[HELD_W-1:0];
        return r;
    endfunction

    function automatic item_t make_item(logic [1:0] op, int ax, int ay, int bx, int by,
                                        bit sp, bit ep, int qx, int qy);
        item_t it;
        it.opcode = op;
        it.start_x = ax[15:0]; it.start_y = ay[15:0];
        it.end_x = bx[15:0];   it.end_y = by[15:0];
        it.start_present = sp; it.end_present = ep;
        it.query_x = qx[15:0]; it.query_y = qy[15:0];
        return it;
    endfunction

    function automatic result_t make_res(bit ins, bit cpl, bit st, int held);
        result_t r;
        r.inside_res = ins;
        r.complete   = cpl;
        r.status     = st;
        r.edges_held = held[HELD_W-1:0];
        return r;
    endfunction

    function automatic void add_row(item_t it, bit typed, result_t r);
        row_t rw;
        rw.it = it;
        rw.typed = typed;
        rw.r = r;
        table_rows.insert(table_rows.size(), rw);
    endfunction

    // one item transfer; the model is advanced at the accepting edge
    task automatic send_item(item_t it, bit typed, result_t r);
        result_t pred;
        bit      acc;
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        item  <= it;
        forever
        begin
            acc = !busy;
            @(posedge clk);
            if (acc)
                break;
            @(negedge clk);
        end
        pred = cell_step(it);
        n_sent++;
        if (it.opcode == OP_TEST)
            n_tests++;
        expected_results.insert(expected_results.size(), typed ? r : pred);
        // drop start so the held item is not taken a second time
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic send(item_t it);
        send_item(it, 1'b0, '0);
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // register write, only while the block is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_BITS-1:0] val);
        bit acc;
        @(negedge clk);
        start     <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        forever
        begin
            acc = cfg_ready;
            @(posedge clk);
            if (acc)
                break;
            @(negedge clk);
        end
        if (idx == REG_FOCUS_X)
            focus_x = longint'(signed'(val));
        else
            focus_y = longint'(signed'(val));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_focus(int fx, int fy);
        wait_drained();
        write_reg(REG_FOCUS_X, fx[15:0]);
        write_reg(REG_FOCUS_Y, fy[15:0]);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            n_results++;
            if (expected_results.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result %p", result);
            end
            else
            begin
                result_t e;
                e = expected_results.pop_front();
                if (result.inside_res && e.inside_res)
                    n_inside++;
                if (result.status)
                    n_dropped++;
                if (result !== e)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: expected %p, got %p", e, result);
                end
            end
        end
    end

    // random convex cell around the focus: subset of octagon corners
    task automatic send_cell(int cx, int cy, int rad, bit make_broken);
        int vx[8];
        int vy[8];
        int px[$];
        int py[$];
        int order[$];
        int dxs[8] = '{1, 1, 0, -1, -1, -1, 0, 1};
        int dys[8] = '{0, 1, 1, 1, 0, -1, -1, -1};
        int n, j, k, tmp, bad;
        item_t it;
        for (int i = 0; i < 8; i++)
        begin
            vx[i] = cx + dxs[i] * rad;
            vy[i] = cy + dys[i] * rad;
        end
        // keep corners at odd steps so the focus stays inside
        for (int i = 0; i < 8; i++)
            if (i % 2 == 1 || $urandom_range(1))
            begin
                px.insert(px.size(), vx[i]);
                py.insert(py.size(), vy[i]);
            end
        n = px.size();
        for (int i = 0; i < n; i++)
            order.insert(order.size(), i);
        for (int i = n - 1; i > 0; i--)
        begin
            k = $urandom_range(i);
            tmp = order[i]; order[i] = order[k]; order[k] = tmp;
        end
        bad = make_broken ? $urandom_range(n - 1) : -1;
        for (int i = 0; i < n; i++)
        begin
            j = order[i];
            k = (j + 1) % n;
            if (i == bad && $urandom_range(1))
                continue;
            if ($urandom_range(1))
                it = make_item(OP_ADD, px[j], py[j], px[k], py[k], 1, 1, 0, 0);
            else
                it = make_item(OP_ADD, px[k], py[k], px[j], py[j], 1, 1, 0, 0);
            if (i == bad)
            begin
                it.start_present = 1'($urandom_range(1));
                it.end_present = !it.start_present;
            end
            send(it);
        end
        repeat ($urandom_range(6, 2))
        begin
            send(make_item(OP_TEST, $urandom, $urandom, $urandom, $urandom, 1'($urandom),
                           1'($urandom), cx + $urandom_range(2 * rad + 4) - rad - 2,
                           cy + $urandom_range(2 * rad + 4) - rad - 2));
        end
    endtask

    initial
    begin
        int rad, cx, cy, choice;
        int focus_mark;
        bit drained_once;
        item_t it;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        focus_x = 0; focus_y = 0;
        edge_cnt = 0; open_cnt = 0; broken = 1'b0;
        n_errors = 0; n_results = 0; n_inside = 0; n_dropped = 0; n_tests = 0;
        n_sent = 0;
        idle_pct = 28;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        add_row(make_item(OP_TEST, 0, 0, 0, 0, 0, 0, 32767, -32768), 1, make_res(1, 1, 0, 0));
        add_row(make_item(OP_NOP, -1, -1, -1, -1, 1, 1, -1, -1), 1, make_res(0, 1, 0, 0));
        add_row(make_item(OP_ADD, 5, 5, 9, 9, 1, 0, 0, 0), 1, make_res(0, 0, 0, 1));
        add_row(make_item(OP_TEST, 0, 0, 0, 0, 0, 0, 0, 0), 1, make_res(0, 0, 0, 1));
        add_row(make_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1, make_res(0, 1, 0, 0));
        add_row(make_item(OP_ADD, 1, 1, 2, 2, 0, 1, 0, 0), 1, make_res(0, 0, 0, 1));
        add_row(make_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1, make_res(0, 1, 0, 0));
        // full-range triangle with one edge backwards, then edges collinear with the focus
        add_row(make_item(OP_ADD, 32767, -32768, 0, 32767, 1, 1, 0, 0), 0, '0);
        add_row(make_item(OP_ADD, -32768, -32768, 0, 32767, 1, 1, 0, 0), 0, '0);
        add_row(make_item(OP_TEST, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
        add_row(make_item(OP_ADD, -32768, -32768, 32767, -32768, 1, 1, 0, 0), 0, '0);
        add_row(make_item(OP_TEST, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
        add_row(make_item(OP_TEST, 0, 0, 0, 0, 0, 0, 32767, 32767), 0, '0);
        add_row(make_item(OP_TEST, 0, 0, 0, 0, 0, 0, -32768, -32768), 0, '0);
        add_row(make_item(OP_TEST, 0, 0, 0, 0, 0, 0, 0, 32767), 0, '0);
        add_row(make_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
        add_row(make_item(OP_ADD, 0, 0, 0, 0, 1, 1, 0, 0), 0, '0);
        add_row(make_item(OP_ADD, -10, -10, 10, 10, 1, 1, 0, 0), 0, '0);
        add_row(make_item(OP_ADD, 10, 10, -10, -10, 1, 1, 0, 0), 0, '0);
        add_row(make_item(OP_TEST, 0, 0, 0, 0, 0, 0, 3, -3), 0, '0);
        add_row(make_item(OP_TEST, 0, 0, 0, 0, 0, 0, -3, 3), 0, '0);
        add_row(make_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
        foreach (table_rows[i])
            send_item(table_rows[i].it, table_rows[i].typed, table_rows[i].r);

        // random part, phases separated by focus changes
        set_focus(32767, -32768);
        focus_mark = 300;
        drained_once = 1'b0;
        while (n_sent < N_ITEMS)
        begin
            idle_pct = (n_sent >= 400 && n_sent < 600) ? 0 : 28;
            if (n_sent >= focus_mark)
            begin
                set_focus($urandom_range(1) ? -32768 : $urandom_range(20000) - 10000,
                          $urandom_range(20000) - 10000);
                focus_mark += 300;
            end
            if (!drained_once && n_sent >= 700)
            begin
                wait_drained();
                drained_once = 1'b1;
            end
            choice = $urandom_range(99);
            if (choice < 70)
            begin
                rad = $urandom_range(3) == 0 ? $urandom_range(15000, 1) : $urandom_range(40, 1);
                cx = int'(focus_x) + int'($urandom_range(2 * (rad / 2))) - rad / 2;
                cy = int'(focus_y) + int'($urandom_range(2 * (rad / 2))) - rad / 2;
                if (cx > 32767 - rad || cx < -32768 + rad || cy > 32767 - rad
                    || cy < -32768 + rad)
                begin
                    cx = 0;
                    cy = 0;
                end
                send(make_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom,
                               1'($urandom), 1'($urandom), $urandom, $urandom));
                send_cell(cx, cy, rad, $urandom_range(4) == 0);
            end
            else if (choice < 76)
            begin
                // overfill the edge store
                repeat (N_EDGES + 4)
                begin
                    it = make_item(OP_ADD, $urandom, $urandom, $urandom, $urandom, 1, 1, 0, 0);
                    send(it);
                end
                send(make_item(OP_TEST, 0, 0, 0, 0, 0, 0, $urandom, $urandom));
            end
            else
            begin
                it = item_t'({$urandom, $urandom, $urandom, 4'($urandom)});
                send(it);
            end
        end

        // drain and finish
        fork
            wait_drained();
            begin
                repeat (200000) @(posedge clk);
            end
        join_any
        disable fork;
        repeat (300) @(posedge clk);
        $display("ran %0d results: %0d point tests, %0d found inside, %0d dropped adds",
                 n_results, n_tests, n_inside, n_dropped);
        if (n_errors == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
        begin
            $display("%0d mismatches, %0d results missing", n_errors, expected_results.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== convex_cell_point_test.f =====
+incdir+sv
sv/ccpt_pkg.sv
sv/ccpt_ram.sv
sv/ccpt_datapath.sv
sv/ccpt_ctrl.sv
sv/convex_cell_point_test.sv
tb/convex_cell_point_test_test.sv
